FILE: sv/lrv_pkg.sv
// ledger record validator: shared types, constants and crc helper
package lrv_pkg;

  localparam int unsigned RECORD_BYTES = 156;
  localparam int unsigned IDX_W        = 8;

  // byte offsets of the record layout
  localparam logic [IDX_W-1:0] OFS_FORMAT     = IDX_W'(4);
  localparam logic [IDX_W-1:0] OFS_LENGTH     = IDX_W'(6);
  localparam logic [IDX_W-1:0] OFS_SCHEMA     = IDX_W'(8);
  localparam logic [IDX_W-1:0] OFS_SEAL       = IDX_W'(12);
  localparam logic [IDX_W-1:0] OFS_REVISION   = IDX_W'(16);
  localparam logic [IDX_W-1:0] OFS_NETWORK    = IDX_W'(24);
  localparam logic [IDX_W-1:0] OFS_AUTHORITY  = IDX_W'(32);
  localparam logic [IDX_W-1:0] OFS_GENERATION = IDX_W'(40);
  localparam logic [IDX_W-1:0] OFS_RESERVED   = IDX_W'(44);
  localparam logic [IDX_W-1:0] OFS_SEQUENCE   = IDX_W'(48);
  localparam logic [IDX_W-1:0] OFS_HASHES     = IDX_W'(56);
  localparam logic [IDX_W-1:0] OFS_CRC        = IDX_W'(RECORD_BYTES - 4);
  localparam logic [IDX_W-1:0] IDX_RECORD     = IDX_W'(RECORD_BYTES);
  localparam logic [IDX_W-1:0] IDX_MAX        = '1;

  localparam logic [31:0] LEDGER_MAGIC  = 32'h524C4131;
  localparam logic [15:0] LEDGER_FORMAT = 16'd1;
  localparam logic [15:0] LEDGER_LENGTH = 16'(RECORD_BYTES);
  localparam logic [31:0] SEAL_PENDING  = 32'h0000_0000;
  localparam logic [31:0] SEAL_COMMIT   = 32'h5A3CC3A5;
  localparam logic [7:0]  FILL_ZERO     = 8'h00;
  localparam logic [7:0]  FILL_ONES     = 8'hFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] SCHEMA_RESET  = 32'd1;

  typedef enum logic [2:0] {
    CLS_EMPTY       = 3'd0,
    CLS_PENDING     = 3'd1,
    CLS_CORRUPT     = 3'd2,
    CLS_UNSUPPORTED = 3'd3,
    CLS_FOREIGN     = 3'd4,
    CLS_VALID       = 3'd5
  } lrv_class_e;

  typedef enum logic [1:0] {
    REG_NETWORK   = 2'd0,
    REG_AUTHORITY = 2'd1,
    REG_SCHEMA    = 2'd2
  } lrv_reg_e;

  typedef struct packed {
    logic [63:0] network_id;
    logic [63:0] authority_id;
    logic [31:0] schema_id;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       fill_byte;
    logic             uniform_flag;
    logic [31:0]      crc_reg;
    logic [31:0]      magic_word;
    logic [15:0]      format_word;
    logic [15:0]      length_word;
    logic [31:0]      schema_word;
    logic [31:0]      seal_word;
    logic [63:0]      revision_word;
    logic [63:0]      network_word;
    logic [63:0]      authority_word;
    logic [31:0]      generation_word;
    logic [63:0]      sequence_word;
    logic [31:0]      stored_crc;
  } rec_t;

  typedef struct packed {
    lrv_class_e  slot_class;
    logic [63:0] revision;
    logic [31:0] generation;
    logic [63:0] applied_seq;
  } res_t;

  localparam rec_t REC_CLEAR = '{
    byte_index:      '0,
    fill_byte:       '0,
    uniform_flag:    1'b1,
    crc_reg:         CRC_INIT,
    magic_word:      '0,
    format_word:     '0,
    length_word:     '0,
    schema_word:     '0,
    seal_word:       '0,
    revision_word:   '0,
    network_word:    '0,
    authority_word:  '0,
    generation_word: '0,
    sequence_word:   '0,
    stored_crc:      '0
  };

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

FILE: sv/lrv_intf.sv
// ledger record validator: byte, result and register write channels

interface lrv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lrv_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  slot_class;
  logic [63:0] revision;
  logic [31:0] generation;
  logic [63:0] applied_seq;

  modport source (output valid, output slot_class, output revision, output generation,
                  output applied_seq, input ready);
  modport sink   (input valid, input slot_class, input revision, input generation,
                  input applied_seq, output ready);
endinterface

interface lrv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: sv/lrv_accum.sv
// ledger record validator: per-byte record state (count, fill, crc, field shifts)
module lrv_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output lrv_pkg::rec_t     rec_nxt_o
);

  lrv_pkg::rec_t rec_q;
  lrv_pkg::rec_t rec_d;

  always_comb begin
    rec_d = rec_q;
    if (rec_q.byte_index < lrv_pkg::IDX_RECORD) begin
      if (rec_q.byte_index == '0) begin
        rec_d.fill_byte    = byte_i;
        rec_d.uniform_flag = (byte_i == lrv_pkg::FILL_ZERO) || (byte_i == lrv_pkg::FILL_ONES);
      end else if (byte_i != rec_q.fill_byte) begin
        rec_d.uniform_flag = 1'b0;
      end

      if (rec_q.byte_index < lrv_pkg::OFS_CRC) begin
        rec_d.crc_reg = lrv_pkg::crc_byte(rec_q.crc_reg, byte_i);
      end

      if (rec_q.byte_index < lrv_pkg::OFS_FORMAT) begin
        rec_d.magic_word = {rec_q.magic_word[23:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_LENGTH) begin
        rec_d.format_word = {rec_q.format_word[7:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_SCHEMA) begin
        rec_d.length_word = {rec_q.length_word[7:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_SEAL) begin
        rec_d.schema_word = {rec_q.schema_word[23:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_REVISION) begin
        rec_d.seal_word = {rec_q.seal_word[23:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_NETWORK) begin
        rec_d.revision_word = {rec_q.revision_word[55:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_AUTHORITY) begin
        rec_d.network_word = {rec_q.network_word[55:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_GENERATION) begin
        rec_d.authority_word = {rec_q.authority_word[55:0], byte_i};
      end else if (rec_q.byte_index < lrv_pkg::OFS_RESERVED) begin
        rec_d.generation_word = {rec_q.generation_word[23:0], byte_i};
      end else if (rec_q.byte_index >= lrv_pkg::OFS_SEQUENCE &&
                   rec_q.byte_index < lrv_pkg::OFS_HASHES) begin
        rec_d.sequence_word = {rec_q.sequence_word[55:0], byte_i};
      end else if (rec_q.byte_index >= lrv_pkg::OFS_CRC) begin
        rec_d.stored_crc = {rec_q.stored_crc[23:0], byte_i};
      end
    end
    // count saturates on overlong input
    if (rec_q.byte_index != lrv_pkg::IDX_MAX) begin
      rec_d.byte_index = rec_q.byte_index + lrv_pkg::IDX_W'(1);
    end
  end

  assign rec_nxt_o = rec_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= lrv_pkg::REC_CLEAR;
    end else if (take_i) begin
      rec_q <= last_i ? lrv_pkg::REC_CLEAR : rec_d;
    end
  end

endmodule

FILE: sv/lrv_resq.sv
// ledger record validator: record classification and two-entry result queue
module lrv_resq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lrv_pkg::rec_t rec_i,
  input  lrv_pkg::cfg_t cfg_i,
  output logic          full_o,
  lrv_res_if.source     res_o
);

  lrv_pkg::res_t res_d;
  lrv_pkg::res_t ent_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          pop;
  logic          intact;

  always_comb begin
    if (rec_i.byte_index != lrv_pkg::IDX_RECORD) begin
      res_d.slot_class = lrv_pkg::CLS_CORRUPT;
    end else if (rec_i.uniform_flag) begin
      res_d.slot_class = lrv_pkg::CLS_EMPTY;
    end else if (rec_i.magic_word != lrv_pkg::LEDGER_MAGIC ||
                 rec_i.format_word != lrv_pkg::LEDGER_FORMAT ||
                 rec_i.length_word != lrv_pkg::LEDGER_LENGTH) begin
      res_d.slot_class = lrv_pkg::CLS_CORRUPT;
    end else if (rec_i.seal_word == lrv_pkg::SEAL_PENDING) begin
      res_d.slot_class = lrv_pkg::CLS_PENDING;
    end else if (rec_i.seal_word != lrv_pkg::SEAL_COMMIT) begin
      res_d.slot_class = lrv_pkg::CLS_CORRUPT;
    end else if (~rec_i.crc_reg != rec_i.stored_crc) begin
      res_d.slot_class = lrv_pkg::CLS_CORRUPT;
    end else if (rec_i.schema_word != cfg_i.schema_id) begin
      res_d.slot_class = lrv_pkg::CLS_UNSUPPORTED;
    end else if (rec_i.network_word != cfg_i.network_id ||
                 rec_i.authority_word != cfg_i.authority_id) begin
      res_d.slot_class = lrv_pkg::CLS_FOREIGN;
    end else begin
      res_d.slot_class = lrv_pkg::CLS_VALID;
    end

    // decoded fields only for records that passed the integrity checks
    intact = (res_d.slot_class == lrv_pkg::CLS_UNSUPPORTED) ||
             (res_d.slot_class == lrv_pkg::CLS_FOREIGN) ||
             (res_d.slot_class == lrv_pkg::CLS_VALID);
    res_d.revision    = intact ? rec_i.revision_word   : '0;
    res_d.generation  = intact ? rec_i.generation_word : '0;
    res_d.applied_seq = intact ? rec_i.sequence_word   : '0;
  end

  assign full_o = cnt_q[1];
  assign pop    = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign res_o.valid       = (cnt_q != 2'd0);
  assign res_o.slot_class  = ent_q[rd_ptr_q].slot_class;
  assign res_o.revision    = ent_q[rd_ptr_q].revision;
  assign res_o.generation  = ent_q[rd_ptr_q].generation;
  assign res_o.applied_seq = ent_q[rd_ptr_q].applied_seq;

endmodule

FILE: sv/ledger_record_validator_core.sv
// ledger record validator: top level with input register and register file
//
//  channel  dir  modport  payload
//  byte_i   in   sink     data_byte[7:0], last_byte
//  res_o    out  source   slot_class[2:0], revision[63:0], generation[31:0],
//                         applied_seq[63:0]
//  cfg_i    in   sink     reg_index[1:0] (network, authority, schema), wr_data[63:0]
//
// one byte per cycle sustained while the input is not stalled; a byte is registered at
// accept and folded into the record state (crc, count, field shifts) when it leaves the
// input register, and a marked byte's result is queued in that step. reset clears the
// record state and loads the register defaults (schema 1). results wait in a two-entry
// queue; input stalls only while a marked byte is held and that queue is full.
module ledger_record_validator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrv_byte_if.sink  byte_i,
  lrv_res_if.source res_o,
  lrv_cfg_if.sink   cfg_i
);

  logic          in_vld_q;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  logic          advance;
  logic          q_full;
  logic          push;
  lrv_pkg::cfg_t cfg_q;
  lrv_pkg::rec_t rec_nxt;

  assign advance      = in_vld_q && (!in_last_q || !q_full);
  assign push         = advance && in_last_q;
  assign byte_i.ready = !in_vld_q || advance;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.network_id   <= '0;
      cfg_q.authority_id <= '0;
      cfg_q.schema_id    <= lrv_pkg::SCHEMA_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (lrv_pkg::lrv_reg_e'(cfg_i.reg_index))
        lrv_pkg::REG_NETWORK:   cfg_q.network_id   <= cfg_i.wr_data;
        lrv_pkg::REG_AUTHORITY: cfg_q.authority_id <= cfg_i.wr_data;
        lrv_pkg::REG_SCHEMA:    cfg_q.schema_id    <= cfg_i.wr_data[31:0];
        default: begin
          // index outside the register list is dropped
        end
      endcase
    end
  end

  lrv_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .rec_nxt_o (rec_nxt)
  );

  lrv_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_nxt),
    .cfg_i  (cfg_q),
    .full_o (q_full),
    .res_o  (res_o)
  );

  // a marked byte never enters a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("result queue overflow");

  // a result only appears after a marked byte was folded in
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(push))
    else $error("result without a marked byte");

  // a held byte keeps its value until it is folded in
  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("held byte lost");

endmodule

FILE: test/tb.sv
// testbench for the ledger record validator: record streams, register settings, result checks
`timescale 1ns / 100ps

module tb;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 100;
  localparam int BURST_SLOTS  = 16;

  typedef enum int {
    R_ZEROS, R_ONES, R_SHORT, R_SHORT_ZEROS, R_LONG, R_LONG_ZEROS, R_NEAR_FILL,
    R_BAD_MAGIC, R_BAD_FORMAT, R_BAD_LENGTH, R_PENDING, R_PENDING_BAD_CRC, R_BAD_SEAL,
    R_BAD_CRC, R_BAD_BODY, R_BAD_SCHEMA, R_BAD_NETWORK, R_BAD_AUTHORITY,
    R_VALID, R_VALID_MIN, R_VALID_MAX
  } rec_shape_e;

  typedef struct packed {
    rec_shape_e          shape;
    bit                  typed;
    lrv_pkg::lrv_class_e cls;
  } dir_row_t;

  typedef struct packed {
    lrv_pkg::lrv_class_e cls;
    logic [63:0]         rev;
    logic [31:0]         gen;
    logic [63:0]         seq;
  } slot_verdict_t;

  typedef struct packed {
    bit            typed;
    slot_verdict_t v;
  } slot_hint_t;

  typedef struct packed {
    logic [7:0]  count;
    logic [7:0]  fill;
    logic        uniform;
    logic [31:0] crc;
    logic [31:0] magic;
    logic [15:0] fmt;
    logic [15:0] len;
    logic [31:0] schema;
    logic [31:0] seal;
    logic [63:0] rev;
    logic [63:0] net;
    logic [63:0] auth;
    logic [31:0] gen;
    logic [63:0] seq;
    logic [31:0] crc_field;
  } rec_acc_t;

  // typed rows carry their class; on the others the class column is only the intent
  localparam dir_row_t DIRECTED_ROWS [9] = '{
    '{R_ZEROS,           1'b1, lrv_pkg::CLS_EMPTY},
    '{R_ONES,            1'b1, lrv_pkg::CLS_EMPTY},
    '{R_SHORT,           1'b1, lrv_pkg::CLS_CORRUPT},
    '{R_LONG,            1'b1, lrv_pkg::CLS_CORRUPT},
    '{R_BAD_MAGIC,       1'b1, lrv_pkg::CLS_CORRUPT},
    '{R_PENDING_BAD_CRC, 1'b1, lrv_pkg::CLS_PENDING},
    '{R_BAD_CRC,         1'b1, lrv_pkg::CLS_CORRUPT},
    '{R_BAD_SCHEMA,      1'b0, lrv_pkg::CLS_UNSUPPORTED},
    '{R_VALID_MAX,       1'b0, lrv_pkg::CLS_VALID}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lrv_byte_if byte_ch ();
  lrv_res_if  res_ch ();
  lrv_cfg_if  cfg_ch ();

  ledger_record_validator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and its copy of the registers
  rec_acc_t    acc;
  logic [63:0] want_network   = '0;
  logic [63:0] want_authority = '0;
  logic [31:0] want_schema    = lrv_pkg::SCHEMA_RESET;

  slot_verdict_t expected_slots [$];
  slot_hint_t    slot_hints [$];
  logic [7:0]    frame [$];

  int fault_count   = 0;
  int slots_checked = 0;
  int class_tally [6];
  int bytes_sent    = 0;
  int records_sent  = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int stall_epoch   = 0;
  int quiet_cycles  = 0;

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (lrv_pkg::CRC_POLY & {32{r[0] ^ b[k]}});
    return r;
  endfunction

  function automatic void clear_acc();
    acc = '0;
    acc.uniform = 1'b1;
    acc.crc = lrv_pkg::CRC_INIT;
  endfunction

  function automatic void fold_byte(input logic [7:0] b);
    int at;
    at = int'(acc.count);
    if (at < lrv_pkg::RECORD_BYTES) begin
      if (at == 0) begin
        acc.fill = b;
        acc.uniform = (b == lrv_pkg::FILL_ZERO) || (b == lrv_pkg::FILL_ONES);
      end else if (b != acc.fill) begin
        acc.uniform = 1'b0;
      end
      if (at < lrv_pkg::OFS_CRC) acc.crc = crc_step(acc.crc, b);
      if (at < lrv_pkg::OFS_FORMAT) acc.magic = {acc.magic[23:0], b};
      else if (at < lrv_pkg::OFS_LENGTH) acc.fmt = {acc.fmt[7:0], b};
      else if (at < lrv_pkg::OFS_SCHEMA) acc.len = {acc.len[7:0], b};
      else if (at < lrv_pkg::OFS_SEAL) acc.schema = {acc.schema[23:0], b};
      else if (at < lrv_pkg::OFS_REVISION) acc.seal = {acc.seal[23:0], b};
      else if (at < lrv_pkg::OFS_NETWORK) acc.rev = {acc.rev[55:0], b};
      else if (at < lrv_pkg::OFS_AUTHORITY) acc.net = {acc.net[55:0], b};
      else if (at < lrv_pkg::OFS_GENERATION) acc.auth = {acc.auth[55:0], b};
      else if (at < lrv_pkg::OFS_RESERVED) acc.gen = {acc.gen[23:0], b};
      else if (at >= lrv_pkg::OFS_SEQUENCE && at < lrv_pkg::OFS_HASHES)
        acc.seq = {acc.seq[55:0], b};
      else if (at >= lrv_pkg::OFS_CRC) acc.crc_field = {acc.crc_field[23:0], b};
    end
    // count saturates on overlong input
    if (acc.count != lrv_pkg::IDX_MAX) acc.count = acc.count + 8'd1;
  endfunction

  function automatic lrv_pkg::lrv_class_e grade_record();
    if (acc.count != lrv_pkg::IDX_RECORD) return lrv_pkg::CLS_CORRUPT;
    if (acc.uniform) return lrv_pkg::CLS_EMPTY;
    if (acc.magic != lrv_pkg::LEDGER_MAGIC || acc.fmt != lrv_pkg::LEDGER_FORMAT ||
        acc.len != lrv_pkg::LEDGER_LENGTH)
      return lrv_pkg::CLS_CORRUPT;
    if (acc.seal == lrv_pkg::SEAL_PENDING) return lrv_pkg::CLS_PENDING;
    if (acc.seal != lrv_pkg::SEAL_COMMIT) return lrv_pkg::CLS_CORRUPT;
    if (~acc.crc != acc.crc_field) return lrv_pkg::CLS_CORRUPT;
    if (acc.schema != want_schema) return lrv_pkg::CLS_UNSUPPORTED;
    if (acc.net != want_network || acc.auth != want_authority) return lrv_pkg::CLS_FOREIGN;
    return lrv_pkg::CLS_VALID;
  endfunction

  // monitor: folds every accepted byte, predicts at each marked byte, checks every accepted result
  initial clear_acc();

  always @(posedge clk_i) begin : monitor
    slot_verdict_t predicted;
    slot_verdict_t oldest;
    slot_hint_t    hint;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (lrv_pkg::lrv_reg_e'(cfg_ch.reg_index))
          lrv_pkg::REG_NETWORK:   want_network = cfg_ch.wr_data;
          lrv_pkg::REG_AUTHORITY: want_authority = cfg_ch.wr_data;
          lrv_pkg::REG_SCHEMA:    want_schema = cfg_ch.wr_data[31:0];
          default: ;
        endcase
      end
      if (byte_ch.valid && byte_ch.ready) begin
        fold_byte(byte_ch.data_byte);
        if (byte_ch.last_byte) begin
          predicted = '0;
          predicted.cls = grade_record();
          if (predicted.cls inside {lrv_pkg::CLS_UNSUPPORTED, lrv_pkg::CLS_FOREIGN,
                                    lrv_pkg::CLS_VALID}) begin
            predicted.rev = acc.rev;
            predicted.gen = acc.gen;
            predicted.seq = acc.seq;
          end
          if (slot_hints.size() != 0) begin
            hint = slot_hints.pop_front();
            if (hint.typed) predicted = hint.v;
          end
          expected_slots.push_back(predicted);
          class_tally[predicted.cls]++;
          clear_acc();
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_slots.size() == 0) begin
          $error("result with no request waiting: slot_class %0d", res_ch.slot_class);
          fault_count++;
        end else begin
          oldest = expected_slots.pop_front();
          if (res_ch.slot_class !== oldest.cls) begin
            $error("slot_class: expected %0d, got %0d", oldest.cls, res_ch.slot_class);
            fault_count++;
          end
          if (res_ch.revision !== oldest.rev) begin
            $error("revision: expected %h, got %h", oldest.rev, res_ch.revision);
            fault_count++;
          end
          if (res_ch.generation !== oldest.gen) begin
            $error("generation: expected %h, got %h", oldest.gen, res_ch.generation);
            fault_count++;
          end
          if (res_ch.applied_seq !== oldest.seq) begin
            $error("applied_seq: expected %h, got %h", oldest.seq, res_ch.applied_seq);
            fault_count++;
          end
          slots_checked++;
        end
      end
    end
  end

  // result side: random stalls plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int seen_epoch;
    hold_left = 0;
    seen_epoch = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (seen_epoch != stall_epoch) begin
        seen_epoch = stall_epoch;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_slots.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void put_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) frame.push_back(v[8*i +: 8]);
  endfunction

  function automatic void fill_frame(input logic [7:0] b, input int n);
    frame.delete();
    repeat (n) frame.push_back(b);
  endfunction

  function automatic void build_frame(input logic [31:0] seal, input logic [31:0] schema,
                                      input logic [63:0] rev, input logic [63:0] net,
                                      input logic [63:0] auth, input logic [31:0] gen,
                                      input logic [63:0] seq);
    logic [31:0] c;
    frame.delete();
    put_be(64'(lrv_pkg::LEDGER_MAGIC), 4);
    put_be(64'(lrv_pkg::LEDGER_FORMAT), 2);
    put_be(64'(lrv_pkg::LEDGER_LENGTH), 2);
    put_be(64'(schema), 4);
    put_be(64'(seal), 4);
    put_be(rev, 8);
    put_be(net, 8);
    put_be(auth, 8);
    put_be(64'(gen), 4);
    put_be(64'($urandom), 4);
    put_be(seq, 8);
    repeat (lrv_pkg::OFS_CRC - lrv_pkg::OFS_HASHES) frame.push_back(8'($urandom));
    c = lrv_pkg::CRC_INIT;
    for (int i = 0; i < lrv_pkg::OFS_CRC; i++) c = crc_step(c, frame[i]);
    put_be(64'(~c), 4);
  endfunction

  function automatic void good_frame(input logic [31:0] seal);
    build_frame(seal, want_schema, rand64(), want_network, want_authority, $urandom, rand64());
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= l;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit typed, input lrv_pkg::lrv_class_e cls);
    slot_hint_t hint;
    hint = '0;
    hint.typed = typed;
    hint.v.cls = cls;
    slot_hints.push_back(hint);
    records_sent++;
    for (int i = 0; i < frame.size(); i++) push_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_slots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input lrv_pkg::lrv_reg_e idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_record();
    int pick;
    int cut;
    logic [63:0] net;
    logic [63:0] auth;
    logic [31:0] schema;
    logic [31:0] seal;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // noise: short run of random bytes
      frame.delete();
      repeat ($urandom_range(40, 1)) frame.push_back(8'($urandom));
    end else if (pick < 9) begin
      fill_frame($urandom_range(1) ? lrv_pkg::FILL_ONES : lrv_pkg::FILL_ZERO,
                 lrv_pkg::RECORD_BYTES + $urandom_range(2) - 1);
    end else begin
      net    = ($urandom_range(99) < 80) ? want_network : rand64();
      auth   = ($urandom_range(99) < 80) ? want_authority : rand64();
      schema = ($urandom_range(99) < 85) ? want_schema : $urandom;
      cut    = $urandom_range(99);
      seal   = (cut < 85) ? lrv_pkg::SEAL_COMMIT : (cut < 93) ? lrv_pkg::SEAL_PENDING : $urandom;
      build_frame(seal, schema, rand64(), net, auth, $urandom, rand64());
      if (pick < 12) begin
        repeat ($urandom_range(120, 1)) frame.push_back(8'($urandom));
      end else if (pick < 15) begin
        cut = $urandom_range(lrv_pkg::RECORD_BYTES - 1, 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end else if ($urandom_range(99) < 15) begin
        cut = $urandom_range(lrv_pkg::RECORD_BYTES - 1);
        frame[cut] = frame[cut] ^ 8'(1 << $urandom_range(7));
      end
    end
    send_frame(1'b0, lrv_pkg::CLS_CORRUPT);
  endtask

  initial begin : stimulus
    dir_row_t row;
    int phase_bytes;
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = lrv_pkg::REG_NETWORK;
    cfg_ch.wr_data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 38;
    rx_idle_pct = 87;
    // directed records against the register defaults
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      case (row.shape)
        R_ZEROS:       fill_frame(lrv_pkg::FILL_ZERO, lrv_pkg::RECORD_BYTES);
        R_ONES:        fill_frame(lrv_pkg::FILL_ONES, lrv_pkg::RECORD_BYTES);
        R_SHORT:       fill_frame(8'hA5, 1);
        R_SHORT_ZEROS: fill_frame(lrv_pkg::FILL_ZERO, lrv_pkg::RECORD_BYTES - 1);
        R_LONG_ZEROS:  fill_frame(lrv_pkg::FILL_ZERO, lrv_pkg::RECORD_BYTES + 1);
        R_LONG: begin
          // runs past the count ceiling
          good_frame(lrv_pkg::SEAL_COMMIT);
          repeat (104) frame.push_back(8'($urandom));
        end
        R_NEAR_FILL: begin
          fill_frame(lrv_pkg::FILL_ONES, lrv_pkg::RECORD_BYTES);
          frame[lrv_pkg::RECORD_BYTES - 1] = lrv_pkg::FILL_ZERO;
        end
        R_BAD_MAGIC: begin
          good_frame(lrv_pkg::SEAL_COMMIT);
          frame[0] = frame[0] ^ 8'h01;
        end
        R_BAD_FORMAT: begin
          good_frame(lrv_pkg::SEAL_COMMIT);
          frame[lrv_pkg::OFS_LENGTH - 1] = 8'h02;
        end
        R_BAD_LENGTH: begin
          good_frame(lrv_pkg::SEAL_COMMIT);
          frame[lrv_pkg::OFS_SCHEMA - 1] = frame[lrv_pkg::OFS_SCHEMA - 1] ^ 8'h01;
        end
        R_PENDING: good_frame(lrv_pkg::SEAL_PENDING);
        R_PENDING_BAD_CRC: begin
          good_frame(lrv_pkg::SEAL_PENDING);
          frame[lrv_pkg::RECORD_BYTES - 1] = frame[lrv_pkg::RECORD_BYTES - 1] ^ 8'h01;
        end
        R_BAD_SEAL: good_frame(lrv_pkg::SEAL_COMMIT ^ 32'h1);
        R_BAD_CRC: begin
          good_frame(lrv_pkg::SEAL_COMMIT);
          frame[lrv_pkg::RECORD_BYTES - 1] = frame[lrv_pkg::RECORD_BYTES - 1] ^ 8'h80;
        end
        R_BAD_BODY: begin
          good_frame(lrv_pkg::SEAL_COMMIT);
          frame[100] = frame[100] ^ 8'h10;
        end
        R_BAD_SCHEMA:
          build_frame(lrv_pkg::SEAL_COMMIT, want_schema + 32'd1, rand64(), want_network,
                      want_authority, $urandom, rand64());
        R_BAD_NETWORK:
          build_frame(lrv_pkg::SEAL_COMMIT, want_schema, rand64(), want_network ^ 64'h1,
                      want_authority, $urandom, rand64());
        R_BAD_AUTHORITY:
          build_frame(lrv_pkg::SEAL_COMMIT, want_schema, rand64(), want_network,
                      want_authority ^ {1'b1, 63'h0}, $urandom, rand64());
        R_VALID_MIN:
          build_frame(lrv_pkg::SEAL_COMMIT, want_schema, '0, want_network, want_authority,
                      '0, '0);
        R_VALID_MAX:
          build_frame(lrv_pkg::SEAL_COMMIT, want_schema, '1, want_network, want_authority,
                      '1, '1);
        default: good_frame(lrv_pkg::SEAL_COMMIT);
      endcase
      send_frame(row.typed, row.cls);
    end

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(lrv_pkg::REG_NETWORK, '1);
          write_reg(lrv_pkg::REG_AUTHORITY, '0);
          write_reg(lrv_pkg::REG_SCHEMA, {$urandom, 32'hFFFF_FFFF});
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 38;
          write_reg(lrv_pkg::REG_NETWORK, rand64());
          write_reg(lrv_pkg::REG_AUTHORITY, '1);
          write_reg(lrv_pkg::REG_SCHEMA, {$urandom, 32'h0});
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(lrv_pkg::REG_NETWORK, '0);
          write_reg(lrv_pkg::REG_AUTHORITY, rand64());
          write_reg(lrv_pkg::REG_SCHEMA, rand64());
        end
      endcase
      phase_bytes = bytes_sent;
      if (ph == 2) begin
        // hold results back while one-byte records keep coming, so the input backs up
        stall_epoch++;
        for (int i = 0; i < BURST_SLOTS; i++) begin
          fill_frame(8'($urandom), 1);
          send_frame(1'b1, lrv_pkg::CLS_CORRUPT);
        end
      end
      while (bytes_sent - phase_bytes < PHASE_BYTES)
        random_record();
    end
    settle();
    repeat (10) @(posedge clk_i);

    $display("covered %0d records in %0d bytes, %0d results checked, reset and three settings",
             records_sent, bytes_sent, slots_checked);
    $display("by class: empty %0d pending %0d corrupt %0d unsupported %0d foreign %0d valid %0d",
             class_tally[lrv_pkg::CLS_EMPTY], class_tally[lrv_pkg::CLS_PENDING],
             class_tally[lrv_pkg::CLS_CORRUPT], class_tally[lrv_pkg::CLS_UNSUPPORTED],
             class_tally[lrv_pkg::CLS_FOREIGN], class_tally[lrv_pkg::CLS_VALID]);
    if (fault_count == 0 && expected_slots.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
